### rtl/fagr_pkg.sv
// ----------------------------------------------------------------------------
// fagr_pkg
// Shared types and codes for the fraction arithmetic / gcd reduction block.
// ----------------------------------------------------------------------------
package fagr_pkg;

    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_DIV = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZDEN   = 2'd1;
    localparam logic [1:0] ST_MINVAL = 2'd2;

    // divider handshake status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // negate when asked, keep low 32 bits
    function automatic logic [31:0] apply_sign(input logic [63:0] mag, input logic neg);
        logic [63:0] v;
        v = neg ? (64'd0 - mag) : mag;
        return v[31:0];
    endfunction

endpackage

### rtl/fagr_div.sv
// ----------------------------------------------------------------------------
// fagr_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module fagr_div #(
    parameter int WIDTH = 31
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WIDTH-1:0]     dividend,
    input  logic [WIDTH-1:0]     divisor,
    output fagr_pkg::div_stat_t  stat,
    output logic [WIDTH-1:0]     quo,
    output logic [WIDTH-1:0]     rem
);
    import fagr_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(WIDTH);
                rem_reg   <= '0;
                quo_reg   <= dividend;
                dvs_reg   <= divisor;
            end else if (busy_reg) begin
                // trial subtract of the divisor from the shifted remainder
                if (!diff[WIDTH]) begin
                    rem_reg <= diff[WIDTH-1:0];
                end else begin
                    rem_reg <= shifted[WIDTH-1:0];
                end
                quo_reg   <= {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

### rtl/fraction_arith_gcd_reduce.sv
// Throughput: one request at a time; the shared restoring divider (one bit a cycle) sets it.
// Reset: aresetn synchronous, active low; clears sequencer and valid flags.
// ----------------------------------------------------------------------------
// fraction_arith_gcd_reduce
// Adds, multiplies or divides two signed fractions and reduces the result by
// its gcd, using one shared multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
module fraction_arith_gcd_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_num, a_den, b_num, b_den (lowest bits first), zero padded to bytes
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_num, res_den (lowest bits first)
    output logic [63:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    import fagr_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;       // product width
    localparam int RW = 2 * W + 1;   // raw sum width
    localparam int MW = 2 * W - 1;   // magnitude width

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_QN   = 3'd4;
    localparam logic [2:0] S_QD   = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;

    logic [2:0]          state_reg;
    logic [1:0]          step_reg;
    logic [1:0]          op_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RW-1:0] num_reg, den_reg;
    logic [MW-1:0]       mn_reg, md_reg, y_reg;
    logic                nneg_reg, dneg_reg;
    logic [31:0]         rnum_reg, rden_reg;
    logic [1:0]          rst_reg;
    logic [31:0]         qn_reg;

    logic                out_valid_reg;
    logic [63:0]         out_data_reg;
    logic [1:0]          out_user_reg;

    // input unpack
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic         in_min, in_zden;
    logic [W-1:0] min_val;

    assign in_an   = s_tdata[W-1:0];
    assign in_ad   = s_tdata[2*W-1:W];
    assign in_bn   = s_tdata[3*W-1:2*W];
    assign in_bd   = s_tdata[4*W-1:3*W];
    assign min_val = {1'b1, {(W-1){1'b0}}};
    assign in_min  = (in_an == min_val) || (in_ad == min_val) ||
                     (in_bn == min_val) || (in_bd == min_val);
    assign in_zden = (in_ad == '0) || (in_bd == '0);

    logic is_add;
    assign is_add = (op_reg != OP_MUL) && (op_reg != OP_DIV);

    // shared multiplier: operands chosen by step
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [RW-1:0] prod_x;

    always_comb begin
        unique case (step_reg)
            2'd0: begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1: begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_x = {prod[PW-1], prod};

    // magnitudes of the raw result
    logic [RW-1:0] num_abs, den_abs;
    assign num_abs = num_reg[RW-1] ? (RW'(0) - num_reg) : num_reg;
    assign den_abs = den_reg[RW-1] ? (RW'(0) - den_reg) : den_reg;

    // shared divider
    div_stat_t     dstat;
    logic          div_start;
    logic [MW-1:0] div_dvd, div_dvs, div_quo, div_rem;

    fagr_div #(.WIDTH(MW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (dstat),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    always_comb begin
        div_start = 1'b0;
        div_dvd   = md_reg;
        div_dvs   = y_reg;
        unique case (state_reg)
            S_CHK: begin
                div_start = (den_reg != '0) && (num_reg != '0);
                div_dvd   = den_abs[MW-1:0];
                div_dvs   = num_abs[MW-1:0];
            end
            S_GCD: begin
                div_start = dstat.done;
                if (div_rem != '0) begin
                    div_dvd = y_reg;
                    div_dvs = div_rem;
                end else begin
                    div_dvd = mn_reg;
                    div_dvs = y_reg;
                end
            end
            S_QN: begin
                div_start = dstat.done;
                div_dvd   = md_reg;
                div_dvs   = y_reg;
            end
            default: ;
        endcase
    end

    logic out_free;
    logic out_valid_next;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // held result stays until taken; S_PUT only leaves once the slot is free
    assign out_valid_next = (out_valid_reg && !m_tready) || (state_reg == S_PUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= s_tuser;
                        an_reg   <= in_an;
                        ad_reg   <= in_ad;
                        bn_reg   <= in_bn;
                        bd_reg   <= in_bd;
                        step_reg <= 2'd0;
                        rnum_reg <= '0;
                        rden_reg <= '0;
                        if (in_min) begin
                            rst_reg   <= ST_MINVAL;
                            state_reg <= S_PUT;
                        end else if (in_zden) begin
                            rst_reg   <= ST_ZDEN;
                            state_reg <= S_PUT;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    step_reg <= step_reg + 2'd1;
                    unique case (step_reg)
                        2'd0: num_reg <= prod_x;
                        2'd1: begin
                            den_reg <= prod_x;
                            if (!is_add) begin
                                state_reg <= S_CHK;
                            end
                        end
                        default: begin
                            num_reg   <= num_reg + prod_x;
                            state_reg <= S_CHK;
                        end
                    endcase
                end
                S_CHK: begin
                    priority if (den_reg == '0) begin
                        rnum_reg  <= '0;
                        rden_reg  <= '0;
                        rst_reg   <= ST_ZDEN;
                        state_reg <= S_PUT;
                    end else if (num_reg == '0) begin
                        rnum_reg  <= '0;
                        rden_reg  <= 32'd1;
                        rst_reg   <= ST_OK;
                        state_reg <= S_PUT;
                    end else begin
                        nneg_reg  <= num_reg[RW-1];
                        dneg_reg  <= den_reg[RW-1];
                        mn_reg    <= num_abs[MW-1:0];
                        md_reg    <= den_abs[MW-1:0];
                        y_reg     <= num_abs[MW-1:0];
                        state_reg <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (dstat.done) begin
                        if (div_rem != '0) begin
                            y_reg <= div_rem;
                        end else begin
                            state_reg <= S_QN;
                        end
                    end
                end
                S_QN: begin
                    if (dstat.done) begin
                        qn_reg    <= apply_sign(64'(div_quo), nneg_reg);
                        state_reg <= S_QD;
                    end
                end
                S_QD: begin
                    if (dstat.done) begin
                        rnum_reg  <= qn_reg;
                        rden_reg  <= apply_sign(64'(div_quo), dneg_reg);
                        rst_reg   <= ST_OK;
                        state_reg <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        out_data_reg  <= {rden_reg, rnum_reg};
                        out_user_reg  <= rst_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    a_ready_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dstat.busy)
        else $error("request taken while divider busy");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> div_dvs != '0)
        else $error("divider started with zero divisor");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZDEN || m_tuser == ST_MINVAL))
        else $error("bad status code");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_OK) |-> m_tdata[63:32] != 32'd0)
        else $error("ok result with zero denominator");
`endif

endmodule
